>>> src/lasq_pkg.sv
// Shared types and constants for the LED strip animation sequencer.
// Holds the channel word layouts, opcodes and the controller/datapath command set.
// No dependencies.
`default_nettype none
package lasq_pkg;

	localparam logic [2:0] OP_OFF     = 3'd0;
	localparam logic [2:0] OP_ON      = 3'd1;
	localparam logic [2:0] OP_WIPE    = 3'd2;
	localparam logic [2:0] OP_FADE    = 3'd3;
	localparam logic [2:0] OP_SET     = 3'd4;
	localparam logic [2:0] OP_ADVANCE = 3'd5;

	localparam int CFG_W = 11;
	localparam logic [CFG_W-1:0] LED_COUNT_RST = 11'd1024;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [7:0]  red_in;
		logic [7:0]  green_in;
		logic [7:0]  blue_in;
		logic [7:0]  step_count;
		logic        reverse_order;
		logic [15:0] hold_in;
	} in_word_t;

	typedef struct packed {
		logic        fill_all;
		logic [9:0]  pixel_sel;
		logic [7:0]  red_out;
		logic [7:0]  green_out;
		logic [7:0]  blue_out;
		logic [15:0] hold_out;
		logic        anim_done;
		logic        rejected;
	} out_word_t;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_WIPE,
		MODE_FADE
	} mode_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_CUR_ZERO,
		ACT_CUR_COL,
		ACT_WIPE_START,
		ACT_FADE_START,
		ACT_ADVANCE
	} act_t;

	typedef enum logic [2:0] {
		KIND_REJECT,
		KIND_FILL_OFF,
		KIND_FILL_COL,
		KIND_CLEAR,
		KIND_WIPE_STEP,
		KIND_FADE_STEP,
		KIND_FINAL
	} kind_t;

	typedef struct packed {
		logic       load_in;
		act_t       act;
		logic       div_start;
		logic [1:0] ch;
		logic       out_load;
		kind_t      kind;
	} cmd_t;

	typedef struct packed {
		mode_t      mode;
		logic [2:0] opcode;
		logic       div_done;
		logic       out_free;
		logic       last;
	} stat_t;

endpackage
`default_nettype wire

>>> src/lasq_div.sv
// Restoring divider: 16-bit dividend by 8-bit divisor, one quotient bit a cycle.
// Uses nothing outside this file.
`default_nettype none
module lasq_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [15:0] dividend,
	input  wire logic [7:0]  divisor,
	output logic             done,
	output logic [15:0]      quotient
);
	logic [7:0]  rem_q;
	logic [15:0] quo_q;
	logic [7:0]  dsr_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [8:0]  trial;
	logic        fits;

	assign trial = {rem_q, quo_q[15]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			// quotient bits shift in as dividend bits shift out
			rem_q <= fits ? 8'(trial - {1'b0, dsr_q}) : trial[7:0];
			quo_q <= {quo_q[14:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

>>> src/lasq_ctrl.sv
// Sequencing state machine: decodes each word and drives the datapath commands.
// Depends on lasq_pkg.
`default_nettype none
module lasq_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire lasq_pkg::stat_t stat,
	output lasq_pkg::cmd_t       cmd
);
	import lasq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEC,
		S_DIV_GO,
		S_DIV_WAIT,
		S_PUT1,
		S_PUT2
	} state_t;

	state_t     state_q, state_d;
	kind_t      kind_q, kind_d;
	logic [1:0] ch_q, ch_d;
	logic       step_kind;

	assign in_ready  = state_q == S_IDLE;
	assign step_kind = kind_q == KIND_WIPE_STEP || kind_q == KIND_FADE_STEP;

	always_comb begin
		state_d       = state_q;
		kind_d        = kind_q;
		ch_d          = ch_q;
		cmd           = '0;
		cmd.act       = ACT_NONE;
		cmd.kind      = kind_q;
		cmd.ch        = ch_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_in = in_valid;
				if (in_valid) state_d = S_DEC;
			end
			S_DEC: begin
				ch_d    = 2'd0;
				state_d = S_IDLE;
				if (stat.mode != MODE_IDLE) begin
					if (stat.opcode <= OP_SET) begin
						kind_d  = KIND_REJECT;
						state_d = S_PUT1;
					end else if (stat.opcode == OP_ADVANCE) begin
						if (stat.mode == MODE_WIPE) begin
							state_d = S_DIV_GO;
						end else begin
							kind_d  = KIND_FADE_STEP;
							state_d = S_PUT1;
						end
					end
				end else begin
					case (stat.opcode)
						OP_OFF: begin
							cmd.act = ACT_CUR_ZERO;
							kind_d  = KIND_FILL_OFF;
							state_d = S_PUT1;
						end
						OP_ON: begin
							cmd.act = ACT_CUR_COL;
							kind_d  = KIND_FILL_COL;
							state_d = S_PUT1;
						end
						OP_WIPE: begin
							cmd.act = ACT_WIPE_START;
							kind_d  = KIND_CLEAR;
							state_d = S_PUT1;
						end
						OP_FADE: begin
							cmd.act = ACT_FADE_START;
							state_d = S_DIV_GO;
						end
						OP_SET: cmd.act = ACT_CUR_COL;
						default: ;
					endcase
				end
			end
			S_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (stat.div_done) begin
					if (ch_q == 2'd2) begin
						// wipe advance shows its step; fade start just settles
						if (stat.mode == MODE_WIPE) begin
							kind_d  = KIND_WIPE_STEP;
							state_d = S_PUT1;
						end else begin
							state_d = S_IDLE;
						end
					end else begin
						ch_d    = ch_q + 2'd1;
						state_d = S_DIV_GO;
					end
				end
			end
			S_PUT1: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					if (step_kind) cmd.act = ACT_ADVANCE;
					state_d = (step_kind && stat.last) ? S_PUT2 : S_IDLE;
				end
			end
			S_PUT2: begin
				cmd.kind = KIND_FINAL;
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= KIND_REJECT;
			ch_q    <= '0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			ch_q    <= ch_d;
		end
	end
endmodule
`default_nettype wire

>>> src/lasq_dp.sv
// Datapath: animation state, divider, result builder and the output register.
// Depends on lasq_pkg and lasq_div.
`default_nettype none
module lasq_dp #(
	parameter int STRIP_MAX = 1024
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire lasq_pkg::in_word_t      in_data,
	input  wire logic                    cfg_we,
	input  wire logic [lasq_pkg::CFG_W-1:0] cfg_wdata,
	input  wire lasq_pkg::cmd_t          cmd,
	output lasq_pkg::stat_t              stat,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output lasq_pkg::out_word_t          out_data
);
	import lasq_pkg::*;

	localparam int LW = $clog2(STRIP_MAX + 1);
	localparam int CW = (LW > CFG_W ? LW : CFG_W) + 1;
	localparam logic [CW-1:0] MAX_C = CW'(STRIP_MAX);

	in_word_t         in_q;
	logic [CFG_W-1:0] led_count_q;
	mode_t            mode_q;
	logic [7:0]       cur_q [3];
	logic [7:0]       tgt_q [3];
	logic [7:0]       col   [3];
	logic             dsign_q [3];
	logic [7:0]       dmag_q  [3];
	logic [7:0]       quot_q  [3];
	logic [7:0]       steps_q;
	logic [7:0]       sc_q;
	logic [LW-1:0]    lc_q;
	logic [LW-1:0]    len_q;
	logic             rev_q;
	logic [15:0]      hold_q;
	out_word_t        out_q;
	logic             out_valid_q;

	logic [CW-1:0]    cnt_ext;
	logic [LW-1:0]    eff_len;
	logic [7:0]       n_in;
	logic [8:0]       sc_next;
	logic             steps_end;
	logic [LW:0]      lc_next;
	logic [LW-1:0]    idx;
	logic [7:0]       fade_v [3];
	logic [15:0]      prod [3];
	logic [15:0]      dvd;
	logic [7:0]       ch_cur, ch_col;
	logic             div_done;
	logic [15:0]      quo;
	out_word_t        res;

	assign col[0] = in_q.red_in;
	assign col[1] = in_q.green_in;
	assign col[2] = in_q.blue_in;

	assign cnt_ext = CW'(led_count_q);
	always_comb begin
		if (cnt_ext == '0)        eff_len = LW'(1);
		else if (cnt_ext > MAX_C) eff_len = LW'(STRIP_MAX);
		else                      eff_len = LW'(cnt_ext);
	end

	assign n_in      = (in_q.step_count == 8'd0) ? 8'd1 : in_q.step_count;
	assign sc_next   = {1'b0, sc_q} + 9'd1;
	assign steps_end = sc_next >= {1'b0, steps_q};
	assign lc_next   = {1'b0, lc_q} + 1'b1;
	assign idx       = rev_q ? LW'(len_q - lc_q - LW'(1)) : lc_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod[i]   = dmag_q[i] * sc_next[7:0];
			fade_v[i] = dsign_q[i] ? 8'(cur_q[i] - prod[i][7:0]) : 8'(cur_q[i] + prod[i][7:0]);
		end
	end

	// wipe: channel*(k+1); fade start: |target - current|
	assign ch_cur = cur_q[cmd.ch];
	assign ch_col = col[cmd.ch];
	always_comb begin
		if (mode_q == MODE_WIPE) dvd = ch_cur * sc_next[7:0];
		else if (ch_col < ch_cur) dvd = {8'd0, 8'(ch_cur - ch_col)};
		else dvd = {8'd0, 8'(ch_col - ch_cur)};
	end

	lasq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (steps_q),
		.done     (div_done),
		.quotient (quo)
	);

	always_comb begin
		res = '0;
		case (cmd.kind)
			KIND_REJECT:   res.rejected = 1'b1;
			KIND_FILL_OFF: begin
				res.fill_all  = 1'b1;
				res.anim_done = 1'b1;
			end
			KIND_FILL_COL: begin
				res.fill_all  = 1'b1;
				res.red_out   = col[0];
				res.green_out = col[1];
				res.blue_out  = col[2];
				res.anim_done = 1'b1;
			end
			KIND_CLEAR:    res.fill_all = 1'b1;
			KIND_WIPE_STEP: begin
				res.pixel_sel = 10'(idx);
				res.red_out   = quot_q[0];
				res.green_out = quot_q[1];
				res.blue_out  = quot_q[2];
				res.hold_out  = hold_q;
			end
			KIND_FADE_STEP: begin
				res.fill_all  = 1'b1;
				res.red_out   = fade_v[0];
				res.green_out = fade_v[1];
				res.blue_out  = fade_v[2];
				res.hold_out  = hold_q;
			end
			KIND_FINAL: begin
				res.fill_all  = 1'b1;
				res.red_out   = cur_q[0];
				res.green_out = cur_q[1];
				res.blue_out  = cur_q[2];
				res.anim_done = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) in_q <= in_data;
		if (cmd.out_load) out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q <= LED_COUNT_RST;
			mode_q      <= MODE_IDLE;
			steps_q     <= 8'd1;
			sc_q        <= '0;
			lc_q        <= '0;
			len_q       <= LW'(1);
			rev_q       <= 1'b0;
			hold_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				cur_q[i]   <= '0;
				tgt_q[i]   <= '0;
				dsign_q[i] <= 1'b0;
				dmag_q[i]  <= '0;
				quot_q[i]  <= '0;
			end
		end else begin
			if (cfg_we) led_count_q <= cfg_wdata;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;

			if (div_done) begin
				if (mode_q == MODE_WIPE) begin
					quot_q[cmd.ch] <= quo[7:0];
				end else begin
					dsign_q[cmd.ch] <= ch_col < ch_cur;
					dmag_q[cmd.ch]  <= quo[7:0];
				end
			end

			case (cmd.act)
				ACT_CUR_ZERO: for (int i = 0; i < 3; i++) cur_q[i] <= '0;
				ACT_CUR_COL:  for (int i = 0; i < 3; i++) cur_q[i] <= col[i];
				ACT_WIPE_START: begin
					for (int i = 0; i < 3; i++) cur_q[i] <= col[i];
					steps_q <= n_in;
					sc_q    <= '0;
					lc_q    <= '0;
					rev_q   <= in_q.reverse_order;
					hold_q  <= in_q.hold_in;
					len_q   <= eff_len;
					mode_q  <= MODE_WIPE;
				end
				ACT_FADE_START: begin
					for (int i = 0; i < 3; i++) tgt_q[i] <= col[i];
					steps_q <= n_in;
					sc_q    <= '0;
					hold_q  <= in_q.hold_in;
					mode_q  <= MODE_FADE;
				end
				ACT_ADVANCE: begin
					if (!steps_end) begin
						sc_q <= sc_next[7:0];
					end else begin
						sc_q <= '0;
						if (mode_q == MODE_WIPE) begin
							if (lc_next >= {1'b0, len_q}) begin
								lc_q   <= '0;
								mode_q <= MODE_IDLE;
							end else begin
								lc_q <= lc_next[LW-1:0];
							end
						end else begin
							for (int i = 0; i < 3; i++) cur_q[i] <= tgt_q[i];
							mode_q <= MODE_IDLE;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign stat.mode     = mode_q;
	assign stat.opcode   = in_q.opcode;
	assign stat.div_done = div_done;
	assign stat.out_free = !out_valid_q || out_ready;
	assign stat.last     = steps_end &&
		(mode_q == MODE_FADE || lc_next >= {1'b0, len_q});

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule
`default_nettype wire

>>> src/led_strip_animation_sequencer_unit.sv
// Top level of the LED strip animation sequencer.
// Depends on lasq_pkg, lasq_ctrl, lasq_dp (and lasq_div below it).
//
//   port group          dir   handshake          word
//   in_*                in    in_valid/in_ready  lasq_pkg::in_word_t
//   out_*               out   out_valid/out_ready lasq_pkg::out_word_t
//   cfg_*               in    cfg_we             led_count, 11 bits
//
// A word is decoded and then gives no result, one result or two, each of which
// may wait on a full output register. A wipe advance runs the 16-bit divider
// once per colour channel and adds the final fill on its last step; a fade
// start runs it once per channel too. One word is in work at a time; while a result
// waits for the output register the controller holds and in_ready stays low.
// Reset is asynchronous and needs no clearing pass.
`default_nettype none
module led_strip_animation_sequencer_unit #(
	parameter int STRIP_MAX = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire lasq_pkg::in_word_t         in_data,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output lasq_pkg::out_word_t             out_data,
	input  wire logic                       cfg_we,
	input  wire logic [lasq_pkg::CFG_W-1:0] cfg_wdata
);
	import lasq_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	lasq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lasq_dp #(
		.STRIP_MAX (STRIP_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);
endmodule
`default_nettype wire
